// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checker files of this block.
// Depends on nothing; every file that asserts includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Property checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

// ----- rtl/pip_pkg.sv -----
// Package for the point-in-polygon winding-angle block.
// Holds angle constants, the CORDIC arctangent table and the back-end state type.
`default_nettype none
package pip_pkg;

  localparam int COORD_BITS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // Signed Q9.14 angle sum.
  localparam int SUM_W = 24;
  localparam logic signed [SUM_W-1:0] PI_Q14      = 24'sd51472;
  localparam logic signed [SUM_W-1:0] ONE_RAD_Q14 = 24'sd16384;

  // Arctangent of 2^-i in Q9.14 radians.
  function automatic logic signed [SUM_W-1:0] atan_q14(input logic [4:0] idx);
    logic signed [SUM_W-1:0] v;
    case (idx)
      5'd0:    v = 24'sd12868;
      5'd1:    v = 24'sd7596;
      5'd2:    v = 24'sd4014;
      5'd3:    v = 24'sd2037;
      5'd4:    v = 24'sd1023;
      5'd5:    v = 24'sd512;
      5'd6:    v = 24'sd256;
      5'd7:    v = 24'sd128;
      5'd8:    v = 24'sd64;
      5'd9:    v = 24'sd32;
      5'd10:   v = 24'sd16;
      5'd11:   v = 24'sd8;
      5'd12:   v = 24'sd4;
      5'd13:   v = 24'sd2;
      5'd14:   v = 24'sd1;
      default: v = 24'sd0;
    endcase
    return v;
  endfunction

  // Back-end sequencer states.
  typedef enum logic [3:0] {
    B_IDLE,
    B_MUL0,
    B_MUL1,
    B_MUL2,
    B_MUL3,
    B_MUL4,
    B_CHK,
    B_NORM,
    B_ITER,
    B_ACC,
    B_NEAR0,
    B_NEAR1,
    B_NEAR2,
    B_NEAR3,
    B_EMIT
  } back_state_t;

endpackage
`default_nettype wire

// ----- rtl/pip_fifo.sv -----
// Two-entry queue between the front and back ends.
// Generic over the width of one job; no package dependency.
`default_nettype none
module pip_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       count_r;
  logic             push, pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      if (push && !pop)      count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire

// ----- rtl/pip_front.sv -----
// Front end: accepts vertices, tracks first and previous vertex, forms edge jobs.
// Depends on nothing beyond its parameters; feeds pip_fifo.
`default_nettype none
module pip_front #(
  parameter int COORD_BITS = 16,
  parameter int AW         = 17,
  parameter int JW         = 137
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [COORD_BITS-1:0] in_query_x,
  input  wire logic signed [COORD_BITS-1:0] in_query_y,
  input  wire logic signed [COORD_BITS-1:0] in_vertex_x,
  input  wire logic signed [COORD_BITS-1:0] in_vertex_y,
  input  wire logic                         in_last,
  output logic                              job_valid,
  input  wire logic                         job_ready,
  output logic [JW-1:0]                     job_data
);

  localparam int DW  = COORD_BITS + 1;
  localparam int PRE = DW - AW;
  localparam int EXW = (DW > 17) ? DW : 17;

  logic signed [COORD_BITS-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic                         in_poly_r;
  logic signed [COORD_BITS-1:0] fx, fy;
  logic signed [DW-1:0]         dx, dy, pdx, pdy, fdx, fdy;
  logic signed [DW-1:0]         sdx, sdy, spdx, spdy, sfdx, sfdy;
  logic [EXW-1:0]               abs_x, abs_y;
  logic                         far;
  logic                         accept;

  assign in_ready  = job_ready;
  assign job_valid = in_valid;
  assign accept    = in_valid && job_ready;

  // The first vertex of a polygon closes onto itself.
  assign fx = in_poly_r ? first_x_r : in_vertex_x;
  assign fy = in_poly_r ? first_y_r : in_vertex_y;

  // Exact differences from the query point.
  assign dx  = DW'(in_vertex_x) - DW'(in_query_x);
  assign dy  = DW'(in_vertex_y) - DW'(in_query_y);
  assign pdx = DW'(prev_x_r) - DW'(in_query_x);
  assign pdy = DW'(prev_y_r) - DW'(in_query_y);
  assign fdx = DW'(fx) - DW'(in_query_x);
  assign fdy = DW'(fy) - DW'(in_query_y);

  // Wide coordinates are scaled down before the angle computation.
  assign sdx  = dx  >>> PRE;
  assign sdy  = dy  >>> PRE;
  assign spdx = pdx >>> PRE;
  assign spdy = pdy >>> PRE;
  assign sfdx = fdx >>> PRE;
  assign sfdy = fdy >>> PRE;

  // Magnitudes for the near-vertex test; beyond 16 bits the vertex is far.
  assign abs_x = dx[DW-1] ? EXW'(-dx) : EXW'(dx);
  assign abs_y = dy[DW-1] ? EXW'(-dy) : EXW'(dy);
  assign far   = (abs_x > EXW'(65535)) || (abs_y > EXW'(65535));

  assign job_data = {!in_poly_r, in_last, far, abs_x[15:0], abs_y[15:0],
                     spdx[AW-1:0], spdy[AW-1:0], sdx[AW-1:0], sdy[AW-1:0],
                     sfdx[AW-1:0], sfdy[AW-1:0]};

  // Polygon tracking state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_poly_r <= 1'b0;
    end else if (accept) begin
      in_poly_r <= !in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev_x_r <= in_vertex_x;
      prev_y_r <= in_vertex_y;
      if (!in_poly_r) begin
        first_x_r <= in_vertex_x;
        first_y_r <= in_vertex_y;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pip_back.sv -----
// Back end: per job, edge angles by shared multiplier and iterative CORDIC,
// near-vertex test, saturating sum and the result register. Uses pip_pkg.
`default_nettype none
module pip_back #(
  parameter int AW           = 17,
  parameter int JW           = 137,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [15:0]   precision,
  input  wire logic          job_valid,
  output logic               job_ready,
  input  wire logic [JW-1:0] job_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               out_inside_res
);

  localparam int MW  = (AW > 17) ? AW : 17;
  localparam int PW  = 2 * MW;
  localparam int ACW = PW + 1;
  localparam int NW  = (ACW > 38) ? ACW : 38;
  localparam int IW  = $clog2(CORDIC_STEPS);
  localparam int SW  = pip_pkg::SUM_W;
  localparam logic [NW-1:0] T37 = NW'(1) << 37;
  localparam logic [NW-1:0] T29 = NW'(1) << 29;
  localparam logic [NW-1:0] T28 = NW'(1) << 28;
  localparam logic [NW-1:0] T20 = NW'(1) << 20;
  localparam logic [IW-1:0] LAST_IT = IW'(CORDIC_STEPS - 1);

  // Job field offsets.
  localparam int O_FDY = 0;
  localparam int O_FDX = AW;
  localparam int O_DY  = 2 * AW;
  localparam int O_DX  = 3 * AW;
  localparam int O_PDY = 4 * AW;
  localparam int O_PDX = 5 * AW;
  localparam int O_NAY = 6 * AW;
  localparam int O_NAX = 6 * AW + 16;
  localparam int O_FAR = 6 * AW + 32;
  localparam int O_LST = 6 * AW + 33;
  localparam int O_FST = 6 * AW + 34;

  pip_pkg::back_state_t state_r, state_nxt;

  logic [JW-1:0]           job_r;
  logic                    sel_r;
  logic signed [PW-1:0]    prod_r;
  logic signed [ACW-1:0]   cross_r, dot_r, nacc_r;
  logic [NW-1:0]           mx_r, my_r, mag;
  logic signed [31:0]      cx_r, cy_r;
  logic signed [SW-1:0]    z_r, sum_r;
  logic [IW-1:0]           it_r;
  logic                    near_r;
  logic                    out_valid_r, out_inside_r;
  logic signed [AW-1:0]    ax, ay, bx, by;
  logic signed [MW-1:0]    op_a, op_b;
  logic signed [PW-1:0]    mul;
  logic signed [ACW-1:0]   prod_ext;
  logic signed [SW:0]      sum_wide;
  logic signed [SW-1:0]    sum_sat;
  logic signed [NW:0]      dot_w, cross_w;
  logic signed [31:0]      cy_sh, cx_sh;
  logic signed [SW-1:0]    atan_v;
  logic                    norm_done, out_free, fold;

  // Edge operands: previous-to-current, then current-to-first.
  assign ax = sel_r ? $signed(job_r[O_DX +: AW]) : $signed(job_r[O_PDX +: AW]);
  assign ay = sel_r ? $signed(job_r[O_DY +: AW]) : $signed(job_r[O_PDY +: AW]);
  assign bx = sel_r ? $signed(job_r[O_FDX +: AW]) : $signed(job_r[O_DX +: AW]);
  assign by = sel_r ? $signed(job_r[O_FDY +: AW]) : $signed(job_r[O_DY +: AW]);

  // Shared multiplier operand selection.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      pip_pkg::B_MUL0:  begin op_a = MW'(ax); op_b = MW'(by); end
      pip_pkg::B_MUL1:  begin op_a = MW'(bx); op_b = MW'(ay); end
      pip_pkg::B_MUL2:  begin op_a = MW'(ax); op_b = MW'(bx); end
      pip_pkg::B_MUL3:  begin op_a = MW'(ay); op_b = MW'(by); end
      pip_pkg::B_NEAR0: begin
        op_a = $signed(MW'(job_r[O_NAX +: 16]));
        op_b = $signed(MW'(job_r[O_NAX +: 16]));
      end
      pip_pkg::B_NEAR1: begin
        op_a = $signed(MW'(job_r[O_NAY +: 16]));
        op_b = $signed(MW'(job_r[O_NAY +: 16]));
      end
      pip_pkg::B_NEAR2: begin
        op_a = $signed(MW'(precision));
        op_b = $signed(MW'(precision));
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mul      = op_a * op_b;
  assign prod_ext = ACW'(prod_r);

  // Magnitudes of dot and cross for normalization.
  assign dot_w   = (NW + 1)'(dot_r);
  assign cross_w = (NW + 1)'(cross_r);
  assign mag     = mx_r | my_r;
  assign norm_done = (mag < T29) && (mag >= T28);

  // A negative dot product whose magnitude normalizes to zero stays unfolded.
  assign fold = dot_r[ACW-1] && (mx_r[29:0] != 30'd0);

  // CORDIC micro-rotation terms.
  assign cy_sh  = cy_r >>> it_r;
  assign cx_sh  = cx_r >>> it_r;
  assign atan_v = pip_pkg::atan_q14(5'(it_r));

  // Saturating sum update.
  assign sum_wide = {z_r[SW-1], z_r} + {sum_r[SW-1], sum_r};
  assign sum_sat  = (sum_wide[SW] != sum_wide[SW-1])
                  ? (sum_wide[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}})
                  : sum_wide[SW-1:0];

  assign out_free = !out_valid_r || out_ready;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pip_pkg::B_IDLE:
        if (job_valid) state_nxt = job_data[O_FST] ? pip_pkg::B_NEAR0 : pip_pkg::B_MUL0;
      pip_pkg::B_MUL0:  state_nxt = pip_pkg::B_MUL1;
      pip_pkg::B_MUL1:  state_nxt = pip_pkg::B_MUL2;
      pip_pkg::B_MUL2:  state_nxt = pip_pkg::B_MUL3;
      pip_pkg::B_MUL3:  state_nxt = pip_pkg::B_MUL4;
      pip_pkg::B_MUL4:  state_nxt = pip_pkg::B_CHK;
      pip_pkg::B_CHK:   state_nxt = (cross_r == '0) ? pip_pkg::B_ACC : pip_pkg::B_NORM;
      pip_pkg::B_NORM:  if (norm_done) state_nxt = pip_pkg::B_ITER;
      pip_pkg::B_ITER:  if (it_r == LAST_IT) state_nxt = pip_pkg::B_ACC;
      pip_pkg::B_ACC:   state_nxt = sel_r ? pip_pkg::B_EMIT : pip_pkg::B_NEAR0;
      pip_pkg::B_NEAR0: state_nxt = pip_pkg::B_NEAR1;
      pip_pkg::B_NEAR1: state_nxt = pip_pkg::B_NEAR2;
      pip_pkg::B_NEAR2: state_nxt = pip_pkg::B_NEAR3;
      pip_pkg::B_NEAR3: state_nxt = job_r[O_LST] ? pip_pkg::B_MUL0 : pip_pkg::B_IDLE;
      pip_pkg::B_EMIT:  if (out_free) state_nxt = pip_pkg::B_IDLE;
      default:          state_nxt = pip_pkg::B_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    job_ready = (state_r == pip_pkg::B_IDLE);
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pip_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == pip_pkg::B_EMIT && out_free) out_valid_r <= 1'b1;
      else if (out_ready)                          out_valid_r <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      pip_pkg::B_IDLE: begin
        if (job_valid) begin
          job_r <= job_data;
          sel_r <= 1'b0;
          if (job_data[O_FST]) begin
            sum_r  <= '0;
            near_r <= 1'b0;
          end
        end
      end
      pip_pkg::B_MUL0: prod_r <= mul;
      pip_pkg::B_MUL1: begin
        cross_r <= prod_ext;
        prod_r  <= mul;
      end
      pip_pkg::B_MUL2: begin
        cross_r <= cross_r - prod_ext;
        prod_r  <= mul;
      end
      pip_pkg::B_MUL3: begin
        dot_r  <= prod_ext;
        prod_r <= mul;
      end
      pip_pkg::B_MUL4: dot_r <= dot_r + prod_ext;
      pip_pkg::B_CHK: begin
        // Collinear edge: zero when pointing the same way, minus pi otherwise.
        z_r  <= dot_r[ACW-1] ? -pip_pkg::PI_Q14 : '0;
        mx_r <= dot_w[NW] ? NW'(-dot_w) : dot_w[NW-1:0];
        my_r <= cross_w[NW] ? NW'(-cross_w) : cross_w[NW-1:0];
      end
      pip_pkg::B_NORM: begin
        if (mag >= T37) begin
          mx_r <= mx_r >> 8;
          my_r <= my_r >> 8;
        end else if (mag >= T29) begin
          mx_r <= mx_r >> 1;
          my_r <= my_r >> 1;
        end else if (mag < T20) begin
          mx_r <= mx_r << 8;
          my_r <= my_r << 8;
        end else if (mag < T28) begin
          mx_r <= mx_r << 1;
          my_r <= my_r << 1;
        end else begin
          // Fold the left half plane onto the right one.
          it_r <= '0;
          cx_r <= $signed({2'b00, mx_r[29:0]});
          if (fold) begin
            cy_r <= cross_r[ACW-1] ? $signed({2'b00, my_r[29:0]})
                                   : -$signed({2'b00, my_r[29:0]});
            z_r  <= (!cross_r[ACW-1] && (my_r[29:0] != 30'd0)) ? pip_pkg::PI_Q14
                                                                : -pip_pkg::PI_Q14;
          end else begin
            cy_r <= cross_r[ACW-1] ? -$signed({2'b00, my_r[29:0]})
                                   : $signed({2'b00, my_r[29:0]});
            z_r  <= '0;
          end
        end
      end
      pip_pkg::B_ITER: begin
        if (cy_r > 0) begin
          cx_r <= cx_r + cy_sh;
          cy_r <= cy_r - cx_sh;
          z_r  <= z_r + atan_v;
        end else begin
          cx_r <= cx_r - cy_sh;
          cy_r <= cy_r + cx_sh;
          z_r  <= z_r - atan_v;
        end
        it_r <= it_r + IW'(1);
      end
      pip_pkg::B_ACC:   sum_r <= sum_sat;
      pip_pkg::B_NEAR0: prod_r <= mul;
      pip_pkg::B_NEAR1: begin
        nacc_r <= prod_ext;
        prod_r <= mul;
      end
      pip_pkg::B_NEAR2: begin
        nacc_r <= nacc_r + prod_ext;
        prod_r <= mul;
      end
      pip_pkg::B_NEAR3: begin
        if (!job_r[O_FAR] && (nacc_r <= prod_ext)) near_r <= 1'b1;
        sel_r <= 1'b1;
      end
      pip_pkg::B_EMIT: begin
        if (out_free) begin
          out_inside_r <= near_r || (sum_r > pip_pkg::ONE_RAD_Q14)
                        || (sum_r < -pip_pkg::ONE_RAD_Q14);
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/point_in_polygon_winding_angle.sv -----
// Top level of the point-in-polygon winding-angle test.
// Depends on pip_pkg, pip_front, pip_fifo and pip_back.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_ready  query_x, query_y, vertex_x, vertex_y, last
//   out      output     out_valid/out_ready inside_res
//   cfg      input      cfg_valid/cfg_ready precision
//
// An edge passes through the multiply states, a check state, normalization, the CORDIC
// rotations and an accumulate state; a collinear edge goes from the check to the accumulate.
// A middle vertex adds a dispatch state and the near-vertex test states; the last vertex
// adds the closing edge and an emit state. The shared multiplier and the single CORDIC
// rotation unit serve every edge in turn. Reset is synchronous; a two-entry queue lets
// the front accept while the back works, and the result register holds a finished result
// while out_ready is low.
`default_nettype none
module point_in_polygon_winding_angle #(
  parameter int COORD_BITS   = pip_pkg::COORD_BITS_DEF,
  parameter int CORDIC_STEPS = pip_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [COORD_BITS-1:0] in_query_x,
  input  wire logic signed [COORD_BITS-1:0] in_query_y,
  input  wire logic signed [COORD_BITS-1:0] in_vertex_x,
  input  wire logic signed [COORD_BITS-1:0] in_vertex_y,
  input  wire logic                         in_last,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_inside_res,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [15:0]                  cfg_precision
);

  localparam int AW = (COORD_BITS > 30) ? 31 : COORD_BITS + 1;
  localparam int JW = 6 * AW + 35;

  logic [15:0]   precision_r;
  logic          f_valid, f_ready, b_valid, b_ready;
  logic [JW-1:0] f_data, b_data;

  // Configuration register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      precision_r <= '0;
    end else if (cfg_valid) begin
      precision_r <= cfg_precision;
    end
  end

  pip_front #(
    .COORD_BITS (COORD_BITS),
    .AW         (AW),
    .JW         (JW)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_query_x  (in_query_x),
    .in_query_y  (in_query_y),
    .in_vertex_x (in_vertex_x),
    .in_vertex_y (in_vertex_y),
    .in_last     (in_last),
    .job_valid   (f_valid),
    .job_ready   (f_ready),
    .job_data    (f_data)
  );

  pip_fifo #(
    .WIDTH (JW)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  pip_back #(
    .AW           (AW),
    .JW           (JW),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .precision      (precision_r),
    .job_valid      (b_valid),
    .job_ready      (b_ready),
    .job_data       (b_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_inside_res (out_inside_res)
  );

endmodule
`default_nettype wire

// ----- rtl/pip_checker.sv -----
// Port-level checker for the point-in-polygon block, bound to its top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module pip_port_props (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_inside_res
);

  // Reset empties the queue and the result register.
  `ASSERT_ALWAYS(a_rst_out, clk, !rst_n |=> !out_valid)
  `ASSERT_ALWAYS(a_rst_in, clk, !rst_n |=> in_ready)

  // A stalled result transfer holds.
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)
  `ASSERT_CLK(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_inside_res))

endmodule

bind point_in_polygon_winding_angle pip_port_props u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_inside_res (out_inside_res)
);
`default_nettype wire
